// ===== hdl/jdbt_pkg.sv =====
package jdbt_pkg;

   // Default sizes, handed to the top level parameters
   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_MAX_CHUNK   = 65536;

   // Fixed field widths of the channels
   localparam int BYTE_W   = 8;
   localparam int TARGET_W = 6;
   localparam int REPORT_W = 17;

   // Context dispatches per byte and the cell row geometry that follows from it
   localparam int PASS_LIMIT = 3;
   localparam int MAX_SHIFT  = PASS_LIMIT;
   localparam int TAP_N      = 2 * MAX_SHIFT + 1;
   localparam int TAP_SEL_W  = $clog2(TAP_N);
   localparam int WIN_KEEP   = 2 * MAX_SHIFT;
   localparam int WIN_READ   = WIN_KEEP + 4;

   // Structural characters
   localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;

   // Scanner contexts held in the stack cells
   typedef enum logic [2:0] {
      CTX_VALUE    = 3'd0,
      CTX_LITERAL  = 3'd1,
      CTX_STRING   = 3'd2,
      CTX_ARRAY    = 3'd3,
      CTX_OBJECT   = 3'd4,
      CTX_PROPERTY = 3'd5
   } ctx_type;

   // Per-byte outcome of the dispatch logic
   typedef struct packed {
      logic hit_start;
      logic hit_end;
      logic end_at_next;
      logic overflow;
      logic escape;
   } scan_flags_type;

   // One result word
   typedef struct packed {
      logic                start_here;
      logic                end_here;
      logic                chunk_done;
      logic                first_start_valid;
      logic [REPORT_W-1:0] first_start_offset;
      logic                last_start_valid;
      logic [REPORT_W-1:0] last_start_offset;
      logic                end_valid;
      logic [REPORT_W-1:0] end_offset;
      logic                overflow;
   } rsp_word_type;

endpackage

// ===== hdl/jdbt_channels.sv =====
interface jdbt_req_if import jdbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              chunk_first;
   logic              chunk_last;

   modport source (output valid, output data_byte, output chunk_first, output chunk_last,
                   input ready);
   modport sink   (input valid, input data_byte, input chunk_first, input chunk_last,
                   output ready);
endinterface

interface jdbt_rsp_if import jdbt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                start_here;
   logic                end_here;
   logic                chunk_done;
   logic                first_start_valid;
   logic [REPORT_W-1:0] first_start_offset;
   logic                last_start_valid;
   logic [REPORT_W-1:0] last_start_offset;
   logic                end_valid;
   logic [REPORT_W-1:0] end_offset;
   logic                overflow;

   modport source (output valid, output start_here, output end_here, output chunk_done,
                   output first_start_valid, output first_start_offset,
                   output last_start_valid, output last_start_offset,
                   output end_valid, output end_offset, output overflow,
                   input ready);
   modport sink   (input valid, input start_here, input end_here, input chunk_done,
                   input first_start_valid, input first_start_offset,
                   input last_start_valid, input last_start_offset,
                   input end_valid, input end_offset, input overflow,
                   output ready);
endinterface

interface jdbt_csr_if import jdbt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target_depth;

   modport source (output valid, output target_depth, input ready);
   modport sink   (input valid, input target_depth, output ready);
endinterface

// ===== hdl/json_depth_boundary_tracker.sv =====
// JSON depth boundary tracker.
// req_bus takes one stream byte per word with chunk_first / chunk_last marks;
// rsp_bus returns exactly one result word per byte, in order. csr_bus writes
// target_depth and is ready whenever reset is low; write it only while no byte
// is in flight.
// A result word shows start_here / end_here for values at the target depth,
// overflow when a push found the stack full, and on the last byte of a chunk
// (chunk_done) the first start, last start and last end offsets of the chunk.
// A byte's result is registered and shows on rsp_bus right after the edge
// that accepts it. Throughput is one byte per cycle while rsp_bus takes each
// result word; all context dispatches of a byte resolve combinationally
// against the top cells of the stack, and the stack cells shift by the net push/pop count on each accepted byte.
// The result register holds its word while rsp_bus.ready is low, and req_bus
// keeps accepting as long as that word is taken in the same cycle.
// Reset (synchronous) leaves one value context on the stack, clears the
// escape flag, the chunk offset and the offset record, and sets
// target_depth to 0; no bytes are taken while reset is high.
module json_depth_boundary_tracker import jdbt_pkg::*; #(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int MAX_CHUNK   = DEF_MAX_CHUNK
) (
   input logic         clock,
   input logic         reset,
   jdbt_req_if.sink    req_bus,
   jdbt_rsp_if.source  rsp_bus,
   jdbt_csr_if.sink    csr_bus
);

   localparam int SZ_W  = $clog2(STACK_DEPTH + 1);
   localparam int OFF_W = $clog2(MAX_CHUNK + 1);

   typedef struct packed {
      logic             first_v;
      logic [OFF_W-1:0] first_off;
      logic             last_v;
      logic [OFF_W-1:0] last_off;
      logic             end_v;
      logic [OFF_W-1:0] end_off;
   } record_type;

   function automatic logic [REPORT_W-1:0] report_off(input logic v,
                                                      input logic [OFF_W-1:0] off);
      logic [OFF_W+REPORT_W-1:0] ext;
      ext = {{REPORT_W{1'b0}}, off};
      return v ? ext[REPORT_W-1:0] : '0;
   endfunction

   logic                  step_en;
   logic [TARGET_W-1:0]   target_ff;
   logic [SZ_W-1:0]       size_ff;
   logic [SZ_W-1:0]       size_in;
   logic                  escape_ff;
   logic [OFF_W-1:0]      offset_ff;
   logic [OFF_W-1:0]      offset_in;
   record_type            rec_ff;
   record_type            rec_in;
   record_type            rec_upd;
   logic [OFF_W-1:0]      pos;
   logic [OFF_W-1:0]      nxt;
   rsp_word_type          rsp_ff;
   rsp_word_type          rsp_in;
   logic                  rsp_valid_ff;
   scan_flags_type        flags;
   logic [TAP_SEL_W-1:0]  shift_sel;
   ctx_type               stack_ctx [STACK_DEPTH];
   ctx_type [WIN_READ-1:0] win_rd;
   ctx_type [WIN_KEEP-1:0] win_wr;

   // Handshakes: take a byte whenever the result register is free or being drained
   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign step_en       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = !reset;

   // Top of the cell row as seen by the dispatch logic
   for (genvar j = 0; j < WIN_READ; j++) begin : g_win
      if (j < STACK_DEPTH) begin : g_live
         assign win_rd[j] = stack_ctx[j];
      end else begin : g_pad
         assign win_rd[j] = CTX_VALUE;
      end
   end

   jdbt_dispatch #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dispatch (
      .data_byte    (req_bus.data_byte),
      .escape       (escape_ff),
      .target_depth (target_ff),
      .size         (size_ff),
      .win_rd       (win_rd),
      .win_wr       (win_wr),
      .size_next    (size_in),
      .shift_sel    (shift_sel),
      .flags        (flags)
   );

   // Row of stack cells, cell 0 holds the top
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      ctx_type [TAP_N-1:0] taps;
      ctx_type             win_val;

      for (genvar k = 0; k < TAP_N; k++) begin : g_tap
         if ((i + MAX_SHIFT - k >= 0) && (i + MAX_SHIFT - k < STACK_DEPTH)) begin : g_nbr
            assign taps[k] = stack_ctx[i + MAX_SHIFT - k];
         end else begin : g_edge
            assign taps[k] = CTX_VALUE;
         end
      end

      if (i < WIN_KEEP) begin : g_top
         assign win_val = win_wr[i];
      end else begin : g_deep
         assign win_val = CTX_VALUE;
      end

      jdbt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_en   (step_en),
         .use_win   (i < WIN_KEEP),
         .win_val   (win_val),
         .shift_sel (shift_sel),
         .taps      (taps),
         .ctx_q     (stack_ctx[i])
      );
   end

   // Chunk offsets, record update and the result word
   always_comb begin
      pos = req_bus.chunk_first ? '0 : offset_ff;
      nxt = (pos < OFF_W'(MAX_CHUNK)) ? pos + OFF_W'(1) : OFF_W'(MAX_CHUNK);

      rec_upd = req_bus.chunk_first ? '0 : rec_ff;
      if (flags.hit_start) begin
         if (!rec_upd.first_v) begin
            rec_upd.first_v   = 1'b1;
            rec_upd.first_off = pos;
         end
         rec_upd.last_v   = 1'b1;
         rec_upd.last_off = pos;
      end
      if (flags.hit_end) begin
         rec_upd.end_v   = 1'b1;
         rec_upd.end_off = flags.end_at_next ? nxt : pos;
      end

      rec_in    = req_bus.chunk_last ? '0 : rec_upd;
      offset_in = req_bus.chunk_last ? '0 : nxt;

      rsp_in.start_here         = flags.hit_start;
      rsp_in.end_here           = flags.hit_end;
      rsp_in.chunk_done         = req_bus.chunk_last;
      rsp_in.first_start_valid  = req_bus.chunk_last && rec_upd.first_v;
      rsp_in.first_start_offset = report_off(rsp_in.first_start_valid, rec_upd.first_off);
      rsp_in.last_start_valid   = req_bus.chunk_last && rec_upd.last_v;
      rsp_in.last_start_offset  = report_off(rsp_in.last_start_valid, rec_upd.last_off);
      rsp_in.end_valid          = req_bus.chunk_last && rec_upd.end_v;
      rsp_in.end_offset         = report_off(rsp_in.end_valid, rec_upd.end_off);
      rsp_in.overflow           = flags.overflow;
   end

   // Advance scanner state on each accepted byte; load the config register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         size_ff   <= SZ_W'(1);
         escape_ff <= 1'b0;
         offset_ff <= '0;
         rec_ff    <= '0;
      end else begin
         if (csr_bus.valid) begin
            target_ff <= csr_bus.target_depth;
         end
         if (step_en) begin
            size_ff   <= size_in;
            escape_ff <= flags.escape;
            offset_ff <= offset_in;
            rec_ff    <= rec_in;
         end
      end
   end

   // Result register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.start_here         = rsp_ff.start_here;
   assign rsp_bus.end_here           = rsp_ff.end_here;
   assign rsp_bus.chunk_done         = rsp_ff.chunk_done;
   assign rsp_bus.first_start_valid  = rsp_ff.first_start_valid;
   assign rsp_bus.first_start_offset = rsp_ff.first_start_offset;
   assign rsp_bus.last_start_valid   = rsp_ff.last_start_valid;
   assign rsp_bus.last_start_offset  = rsp_ff.last_start_offset;
   assign rsp_bus.end_valid          = rsp_ff.end_valid;
   assign rsp_bus.end_offset         = rsp_ff.end_offset;
   assign rsp_bus.overflow           = rsp_ff.overflow;

`ifndef NO_ASSERTIONS
   // Every accepted byte shows up as a result word in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_bus.valid)
      else $error("accepted byte produced no result word");

   // A first start is only ever reported together with a last start at chunk end
   a_first_implies_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.first_start_valid |->
         rsp_bus.last_start_valid && rsp_bus.chunk_done)
      else $error("first start reported without last start or outside chunk end");

   // The last byte of a chunk leaves a cleared offset and record
   a_chunk_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && req_bus.chunk_last |=>
         (offset_ff == '0) && !rec_ff.first_v && !rec_ff.last_v && !rec_ff.end_v)
      else $error("chunk state not cleared after last byte");
`endif

endmodule

// ===== hdl/jdbt_cell.sv =====
module jdbt_cell import jdbt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 use_win,
   input  ctx_type              win_val,
   input  logic [TAP_SEL_W-1:0] shift_sel,
   input  ctx_type [TAP_N-1:0]  taps,
   output ctx_type              ctx_q
);

   ctx_type ctx_ff;
   ctx_type ctx_in;

   // Take the rewritten top entry, the neighbor the net shift points at, or hold when the shift is out of range
   always_comb begin
      if (use_win) begin
         ctx_in = win_val;
      end else if (shift_sel < TAP_SEL_W'(TAP_N)) begin
         ctx_in = taps[shift_sel];
      end else begin
         ctx_in = ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= CTX_VALUE;
      end else if (step_en) begin
         ctx_ff <= ctx_in;
      end
   end

   assign ctx_q = ctx_ff;

endmodule

// ===== hdl/jdbt_dispatch.sv =====
module jdbt_dispatch import jdbt_pkg::*; #(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic [BYTE_W-1:0]                    data_byte,
   input  logic                                 escape,
   input  logic [TARGET_W-1:0]                  target_depth,
   input  logic [$clog2(STACK_DEPTH+1)-1:0]     size,
   input  ctx_type [WIN_READ-1:0]               win_rd,
   output ctx_type [WIN_KEEP-1:0]               win_wr,
   output logic [$clog2(STACK_DEPTH+1)-1:0]     size_next,
   output logic [TAP_SEL_W-1:0]                 shift_sel,
   output scan_flags_type                       flags
);

   localparam int SZ_W  = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (SZ_W > TARGET_W + 1) ? SZ_W : TARGET_W + 1;

   // Working view of the stack top while the passes run; shift is offset by MAX_SHIFT
   typedef struct packed {
      ctx_type [WIN_READ-1:0] win;
      logic [SZ_W-1:0]        size;
      logic [TAP_SEL_W-1:0]   shift;
      logic                   hit_start;
      logic                   hit_end;
      logic                   end_at_next;
      logic                   overflow;
   } work_type;

   logic is_space;
   logic is_open;

   assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                     (data_byte == CH_CR) || (data_byte == CH_LF);
   assign is_open  = (data_byte == CH_QUOTE) || (data_byte == CH_LBRACKET) ||
                     (data_byte == CH_LBRACE);

   // Push onto the top; drop and flag when the stack is full
   function automatic work_type push_ctx(input work_type w, input ctx_type c);
      work_type r;
      r = w;
      if (w.size < SZ_W'(STACK_DEPTH)) begin
         for (int k = WIN_READ - 1; k > 0; k--) begin
            r.win[k] = w.win[k-1];
         end
         r.win[0] = c;
         r.size   = w.size + SZ_W'(1);
         r.shift  = w.shift + TAP_SEL_W'(1);
      end else begin
         r.overflow = 1'b1;
      end
      return r;
   endfunction

   // Pop the top; an exit that leaves target_depth+1 entries is a boundary
   function automatic work_type pop_ctx(input work_type w, input logic at_next,
                                        input logic [TARGET_W-1:0] tgt);
      work_type r;
      ctx_type  cur;
      r   = w;
      cur = w.win[0];
      for (int k = 0; k < WIN_READ - 1; k++) begin
         r.win[k] = w.win[k+1];
      end
      r.win[WIN_READ-1] = CTX_VALUE;
      r.size  = w.size - SZ_W'(1);
      r.shift = w.shift - TAP_SEL_W'(1);
      if (CMP_W'(r.size) == CMP_W'(tgt) + CMP_W'(1)) begin
         if (cur == CTX_VALUE) begin
            r.hit_start = 1'b1;
         end else begin
            r.hit_end     = 1'b1;
            r.end_at_next = at_next;
         end
      end
      return r;
   endfunction

   // Run up to PASS_LIMIT context dispatches on the byte
   always_comb begin
      work_type w;
      logic     done;
      logic     esc;
      w.win         = win_rd;
      w.size        = size;
      w.shift       = TAP_SEL_W'(MAX_SHIFT);
      w.hit_start   = 1'b0;
      w.hit_end     = 1'b0;
      w.end_at_next = 1'b0;
      w.overflow    = 1'b0;
      done          = 1'b0;
      esc           = escape;
      for (int p = 0; p < PASS_LIMIT; p++) begin
         if (!done) begin
            // restart a top-level value on an emptied stack
            if (w.size == '0) begin
               w = push_ctx(w, CTX_VALUE);
            end
            unique case (w.win[0])
               CTX_VALUE: begin
                  if (is_open) begin
                     w = pop_ctx(w, 1'b0, target_depth);
                     if (data_byte == CH_QUOTE) begin
                        w = push_ctx(w, CTX_STRING);
                     end else if (data_byte == CH_LBRACKET) begin
                        w = push_ctx(w, CTX_ARRAY);
                     end else begin
                        w = push_ctx(w, CTX_OBJECT);
                     end
                     done = 1'b1;
                  end else if (is_space) begin
                     done = 1'b1;
                  end else begin
                     w = pop_ctx(w, 1'b0, target_depth);
                     w = push_ctx(w, CTX_LITERAL);
                  end
               end
               CTX_LITERAL: begin
                  if ((data_byte == CH_COMMA) || (data_byte == CH_RBRACKET) ||
                      (data_byte == CH_RBRACE) || is_space) begin
                     w = pop_ctx(w, 1'b0, target_depth);
                  end else begin
                     done = 1'b1;
                  end
               end
               CTX_STRING: begin
                  if (esc) begin
                     esc = 1'b0;
                  end else if (data_byte == CH_BSLASH) begin
                     esc = 1'b1;
                  end else if (data_byte == CH_QUOTE) begin
                     w = pop_ctx(w, 1'b1, target_depth);
                  end
                  done = 1'b1;
               end
               CTX_ARRAY: begin
                  if (is_space) begin
                     done = 1'b1;
                  end else if (data_byte == CH_RBRACKET) begin
                     w    = pop_ctx(w, 1'b1, target_depth);
                     done = 1'b1;
                  end else begin
                     w    = push_ctx(w, CTX_VALUE);
                     done = (data_byte == CH_COMMA);
                  end
               end
               CTX_OBJECT: begin
                  if (is_space) begin
                     done = 1'b1;
                  end else if (data_byte == CH_RBRACE) begin
                     w    = pop_ctx(w, 1'b1, target_depth);
                     done = 1'b1;
                  end else begin
                     w    = push_ctx(w, CTX_PROPERTY);
                     w    = push_ctx(w, CTX_VALUE);
                     done = (data_byte == CH_COMMA);
                  end
               end
               default: begin
                  // property: a colon hands over to its value
                  if (data_byte == CH_COLON) begin
                     w = pop_ctx(w, 1'b0, target_depth);
                     w = push_ctx(w, CTX_VALUE);
                  end
                  done = 1'b1;
               end
            endcase
         end
      end
      win_wr            = w.win[WIN_KEEP-1:0];
      size_next         = w.size;
      shift_sel         = w.shift;
      flags.hit_start   = w.hit_start;
      flags.hit_end     = w.hit_end;
      flags.end_at_next = w.end_at_next;
      flags.overflow    = w.overflow;
      flags.escape      = esc;
   end

endmodule
